/* sv/fpm_pkg.sv */
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types and constants of the FSK PWM packet modulator.
// ----------------------------------------------------------------------------
package fpm_pkg;

  localparam int MAX_BYTES = 64;
  localparam int STORE_AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [10:0] MAX_BYTES_L = 11'(MAX_BYTES);

  localparam int BIT_POS_W  = 10;
  localparam int BYTE_POS_W = BIT_POS_W - 3;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] REG_PERIOD_ZERO = 3'd0;
  localparam logic [2:0] REG_PERIOD_ONE  = 3'd1;
  localparam logic [2:0] REG_EDGES_ZERO  = 3'd2;
  localparam logic [2:0] REG_EDGES_ONE   = 3'd3;
  localparam logic [2:0] REG_BIT_COUNT   = 3'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic                 antenna_level;
    logic [BIT_POS_W-1:0] current_bit;
    logic                 busy_res;
    logic                 done_res;
  } out_t;

  typedef struct packed {
    logic [15:0]          period_zero;
    logic [15:0]          period_one;
    logic [15:0]          edges_zero;
    logic [15:0]          edges_one;
    logic [BIT_POS_W-1:0] bit_count;
  } cfg_t;

endpackage

/* sv/fpm_ram.sv */
// ----------------------------------------------------------------------------
// fpm_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module fpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/fpm_cfg.sv */
// ----------------------------------------------------------------------------
// fpm_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module fpm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output fpm_pkg::cfg_t                  cfg
);

  logic [2:0] reg_index;
  logic       wr;

  assign reg_index = paddr[fpm_pkg::CFG_ADDR_W-1:2];
  assign wr        = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_zero <= 16'd100;
      cfg.period_one  <= 16'd80;
      cfg.edges_zero  <= 16'd8;
      cfg.edges_one   <= 16'd10;
      cfg.bit_count   <= 10'd96;
    end else if (wr) begin
      case (reg_index)
        fpm_pkg::REG_PERIOD_ZERO: cfg.period_zero <= pwdata[15:0];
        fpm_pkg::REG_PERIOD_ONE:  cfg.period_one  <= pwdata[15:0];
        fpm_pkg::REG_EDGES_ZERO:  cfg.edges_zero  <= pwdata[15:0];
        fpm_pkg::REG_EDGES_ONE:   cfg.edges_one   <= pwdata[15:0];
        fpm_pkg::REG_BIT_COUNT:   cfg.bit_count   <= pwdata[fpm_pkg::BIT_POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      fpm_pkg::REG_PERIOD_ZERO: prdata = {16'd0, cfg.period_zero};
      fpm_pkg::REG_PERIOD_ONE:  prdata = {16'd0, cfg.period_one};
      fpm_pkg::REG_EDGES_ZERO:  prdata = {16'd0, cfg.edges_zero};
      fpm_pkg::REG_EDGES_ONE:   prdata = {16'd0, cfg.edges_one};
      fpm_pkg::REG_BIT_COUNT:   prdata = {22'd0, cfg.bit_count};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

/* sv/fpm_engine.sv */
// ----------------------------------------------------------------------------
// fpm_engine
// Modulator state, packet store and per-word update logic.
// ----------------------------------------------------------------------------
module fpm_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          proc,
  input  fpm_pkg::in_t  word,
  input  fpm_pkg::cfg_t cfg,
  output fpm_pkg::out_t res
);

  localparam int AW = fpm_pkg::STORE_AW;
  localparam int BW = fpm_pkg::BIT_POS_W;
  localparam int YW = fpm_pkg::BYTE_POS_W;

  logic [15:0]   pwm, pwm_next;
  logic [15:0]   edge_cnt, edge_cnt_next;
  logic [BW-1:0] bit_pos, bit_pos_next;
  logic          running, running_next;
  logic          rd_pending;
  logic [7:0]    cur_byte, cur_byte_next;
  logic [7:0]    nxt_byte, nxt_byte_next;
  logic [7:0]    sh0, sh0_next;
  logic [7:0]    sh1, sh1_next;

  logic          we, rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rdata;
  logic          done;

  logic [YW-1:0] byte_pos;
  logic          bit_now, bit_after;
  logic [15:0]   p_now, e_now, p_after;
  logic [16:0]   pwm_inc, pwm_wrap, edge_inc;
  logic          fall, edge_done, stop_now, stop_adv;
  logic [BW-1:0] bp1;
  logic [YW-1:0] rd_byte;

  function automatic logic bit_of(logic [BW-1:0] pos, logic [7:0] b);
    logic beyond;
    beyond = 11'(pos[BW-1:3]) >= fpm_pkg::MAX_BYTES_L;
    return beyond ? 1'b0 : b[3'd7 - pos[2:0]];
  endfunction

  function automatic logic [15:0] period_of(logic sel, fpm_pkg::cfg_t c);
    logic [15:0] p;
    p = sel ? c.period_one : c.period_zero;
    return (p < 16'd2) ? 16'd2 : p;
  endfunction

  fpm_ram #(.WIDTH(8), .DEPTH(fpm_pkg::MAX_BYTES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(word.byte_index)),
    .wdata (word.byte_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign byte_pos = bit_pos[BW-1:3];
  assign bit_now  = bit_of(bit_pos, cur_byte);
  assign p_now    = period_of(bit_now, cfg);
  assign e_now    = bit_now ? ((cfg.edges_one == 16'd0) ? 16'd1 : cfg.edges_one)
                            : ((cfg.edges_zero == 16'd0) ? 16'd1 : cfg.edges_zero);
  assign pwm_inc   = {1'b0, pwm} + 17'd1;
  assign pwm_wrap  = (pwm_inc >= {1'b0, p_now}) ? 17'd0 : pwm_inc;
  assign fall      = pwm_wrap == {2'b00, p_now[15:1]};
  assign edge_inc  = {1'b0, edge_cnt} + 17'd1;
  assign edge_done = edge_inc >= {1'b0, e_now};
  assign bp1       = bit_pos + BW'(1);
  assign stop_now  = bit_pos >= cfg.bit_count;
  assign stop_adv  = bp1 >= cfg.bit_count;
  assign rd_byte   = byte_pos + YW'(2);

  always_comb begin
    pwm_next      = pwm;
    edge_cnt_next = edge_cnt;
    bit_pos_next  = bit_pos;
    running_next  = running;
    cur_byte_next = cur_byte;
    nxt_byte_next = rd_pending ? rdata : nxt_byte;
    sh0_next      = sh0;
    sh1_next      = sh1;
    we            = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = AW'(rd_byte);
    done          = 1'b0;
    if (proc) begin
      case (word.operation)
        fpm_pkg::OP_WRITE: begin
          if (11'(word.byte_index) < fpm_pkg::MAX_BYTES_L) begin
            we = 1'b1;
            if (word.byte_index == 6'd0) begin
              sh0_next = word.byte_value;
            end
            if (word.byte_index == 6'd1) begin
              sh1_next = word.byte_value;
            end
            if (YW'(word.byte_index) == byte_pos) begin
              cur_byte_next = word.byte_value;
            end
            if (YW'(word.byte_index) == byte_pos + YW'(1)) begin
              nxt_byte_next = word.byte_value;
            end
          end
        end
        fpm_pkg::OP_START: begin
          pwm_next      = 16'd0;
          edge_cnt_next = 16'd0;
          bit_pos_next  = '0;
          running_next  = cfg.bit_count != '0;
          cur_byte_next = sh0;
          nxt_byte_next = sh1;
        end
        fpm_pkg::OP_TICK: begin
          if (running) begin
            if (stop_now) begin
              bit_pos_next = cfg.bit_count;
              running_next = 1'b0;
              done         = 1'b1;
            end else begin
              pwm_next = pwm_wrap[15:0];
              if (fall) begin
                if (edge_done) begin
                  edge_cnt_next = 16'd0;
                  if (stop_adv) begin
                    bit_pos_next = cfg.bit_count;
                    running_next = 1'b0;
                    done         = 1'b1;
                  end else begin
                    bit_pos_next = bp1;
                  end
                  if (bp1[2:0] == 3'd0) begin
                    cur_byte_next = nxt_byte;
                    rd_en = 11'(rd_byte) < fpm_pkg::MAX_BYTES_L;
                  end
                end else begin
                  edge_cnt_next = edge_inc[15:0];
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign bit_after = bit_of(bit_pos_next, cur_byte_next);
  assign p_after   = period_of(bit_after, cfg);

  assign res.antenna_level = running_next && (pwm_next < {1'b0, p_after[15:1]});
  assign res.current_bit   = bit_pos_next;
  assign res.busy_res      = running_next;
  assign res.done_res      = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm        <= 16'd0;
      edge_cnt   <= 16'd0;
      bit_pos    <= '0;
      running    <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      pwm        <= pwm_next;
      edge_cnt   <= edge_cnt_next;
      bit_pos    <= bit_pos_next;
      running    <= running_next;
      rd_pending <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
    nxt_byte <= nxt_byte_next;
    sh0      <= sh0_next;
    sh1      <= sh1_next;
  end

  a_rd_single: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> !rd_en)
    else $error("store read issued while a refill is still pending");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (!running && !(proc && word.operation == fpm_pkg::OP_START)) |=> !running)
    else $error("transmission began without a start word");

  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (proc && word.operation == fpm_pkg::OP_START)
      |=> (pwm == 16'd0 && edge_cnt == 16'd0 && bit_pos == '0))
    else $error("start word did not clear the counters");

endmodule

/* sv/fsk_pwm_packet_modulator_core.sv */
// ----------------------------------------------------------------------------
// fsk_pwm_packet_modulator_core
// Binary FSK square-wave modulator sending bits from a packet store.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) carries one word per tick,
// packet byte write or start command. Every accepted word produces exactly one
// result word on the output channel (out_valid, out_stall, out_data) holding
// the antenna level, the current bit index, busy and the done pulse.
// A word is captured in an input register, processed in a single pass through
// the modulator logic and placed in the output register; one word is taken
// every cycle while the receiver does not stall.
// The packet bytes live in a RAM; the byte being sent and the byte after it
// are held in registers, and at each byte boundary the RAM read that refills
// the following byte is registered and then loaded into the next-byte register.
// Reset clears the counters and the running flag and restores the default
// periods, edge counts and bit total; the packet store is undefined until
// written. While the receiver stalls, the result is held, one more word is
// buffered in the input register, and then in_stall is raised. The user must
// write APB-style registers only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module fsk_pwm_packet_modulator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fpm_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fpm_pkg::out_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  fpm_pkg::cfg_t cfg;
  fpm_pkg::in_t  s1_data;
  fpm_pkg::out_t res;
  logic          s1_valid;
  logic          advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  fpm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpm_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .proc (s1_valid && advance),
    .word (s1_data),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
    if (advance && s1_valid) begin
      out_data <= res;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.done_res) |-> !out_data.busy_res)
    else $error("done reported while still busy");

  a_low_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.busy_res) |-> !out_data.antenna_level)
    else $error("antenna driven high while idle");

  a_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

endmodule
